### design/bce_pkg.sv
// Shared constants and codes for the battery charge estimator.
package bce_pkg;

    localparam int CURVE_DEPTH = 8;
    localparam int PT_W        = $clog2(CURVE_DEPTH);
    localparam int CNT_W       = $clog2(CURVE_DEPTH + 1);
    localparam int CHARGE_W    = 38;
    localparam int MV_W        = 15;
    localparam int SOC_W       = 10;
    localparam int Q_W         = 18;
    localparam int DIV_W       = 56;
    localparam int DCNT_W      = 5;

    localparam logic [21:0]         MS_PER_HOUR   = 22'd3600000;
    localparam logic [15:0]         CAP_RESET     = 16'd10000;
    localparam logic [CHARGE_W-1:0] FULL_RESET    = 38'd36000000000;
    localparam logic [MV_W-1:0]     FULL_ZONE_RST = 15'd12300;
    localparam logic [MV_W-1:0]     DEEP_ZONE_RST = 15'd9700;
    localparam logic [3:0]          POINTS_RESET  = 4'd8;
    localparam logic [SOC_W-1:0]    SOC_MAX       = 10'd1000;
    localparam logic [Q_W-1:0]      CURVE_TOP     = 18'd256000;
    localparam logic [16:0]         RECIP_5       = 17'd52429;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_SAMPLE  = 2'd1,
        ACT_RESTORE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_CAPACITY  = 2'd0,
        CFG_FULL_ZONE = 2'd1,
        CFG_DEEP_ZONE = 2'd2,
        CFG_POINTS    = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ZONE_MID  = 2'd0,
        ZONE_FULL = 2'd1,
        ZONE_DEEP = 2'd2
    } zone_t;

endpackage

### design/battery_charge_estimator_unit.sv
// Battery charge estimator: coulomb counting blended with a voltage curve lookup.
// Each item runs a curve scan that reads and compares each curve point in use (ending
// at once when the voltage is at or above the first curve point), then an 18-step segment
// division when the segment needs one, then an 18-step coulomb division, both on one shared
// restoring divider. A new item is accepted only once the previous one is finished.
// Reset: asynchronous, active low; control and config registers return to defaults, charge to full.
module battery_charge_estimator_unit
    import bce_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           action,
    input  logic [2:0]           point_index,
    input  logic [14:0]          point_voltage_mv,
    input  logic [9:0]           point_soc,
    input  logic signed [15:0]   cell_current,
    input  logic [14:0]          voltage_mv,
    input  logic [15:0]          elapsed_ms,
    input  logic [37:0]          restore_charge,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [37:0]          charge_mams,
    output logic [9:0]           soc_tenths,
    output logic [1:0]           zone,
    output logic                 restore_ok,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_APPLY, S_RD, S_CMP, S_MUL, S_COUL, S_DIV, S_FIN
    } state_t;

    state_t                 state_reg;
    logic [CHARGE_W-1:0]    full_reg;
    logic [CHARGE_W-1:0]    charge_reg;
    logic [MV_W-1:0]        full_zone_reg;
    logic [MV_W-1:0]        deep_zone_reg;
    logic [3:0]             points_reg;

    // latched item
    action_t                act_reg;
    logic [PT_W-1:0]        pidx_reg;
    logic [MV_W-1:0]        pv_reg;
    logic [SOC_W-1:0]       ps_reg;
    logic signed [15:0]     cur_reg;
    logic [MV_W-1:0]        v_reg;
    logic [15:0]            el_reg;
    logic [CHARGE_W-1:0]    rc_reg;
    logic                   ok_reg;

    // curve storage and scan
    logic [MV_W-1:0]        curve_v [CURVE_DEPTH];
    logic [SOC_W-1:0]       curve_s [CURVE_DEPTH];
    logic [MV_W-1:0]        rd_v_reg;
    logic [SOC_W-1:0]       rd_s_reg;
    logic [PT_W-1:0]        idx_reg;
    logic [MV_W-1:0]        prev_v_reg;
    logic [SOC_W-1:0]       prev_s_reg;
    logic                   found_reg;
    logic [MV_W-1:0]        seg_v1_reg;
    logic [MV_W-1:0]        seg_v2_reg;
    logic [SOC_W-1:0]       seg_s1_reg;
    logic [SOC_W-1:0]       seg_s2_reg;

    // shared divider
    logic [DIV_W-1:0]       rem_reg;
    logic [CHARGE_W-1:0]    dvs_reg;
    logic [Q_W-1:0]         q_reg;
    logic [DCNT_W-1:0]      dcnt_reg;
    logic                   div_coul_reg;
    logic                   neg_reg;

    logic signed [19:0]     volt_reg;
    logic [CHARGE_W-1:0]    out_charge_reg;
    logic [SOC_W-1:0]       out_soc_reg;
    logic [1:0]             out_zone_reg;
    logic                   out_ok_reg;
    logic                   out_valid_reg;

    logic signed [32:0]     cur_prod;
    logic signed [39:0]     charge_sum;
    logic [CHARGE_W-1:0]    charge_clamped;
    logic [15:0]            cap_wr;
    logic [CHARGE_W-1:0]    full_wr;
    logic [3:0]             n_used;
    logic [PT_W-1:0]        last_idx;
    logic                   seg_hit;
    logic [MV_W-1:0]        seg_den;
    logic [MV_W-1:0]        seg_dv;
    logic signed [10:0]     seg_ds;
    logic [SOC_W-1:0]       seg_ds_mag;
    logic [24:0]            seg_mag;
    logic [44:0]            charge_125;
    logic [DIV_W-1:0]       trial;
    logic                   div_ge;
    logic [Q_W-1:0]         q_shift;
    logic signed [19:0]     q_signed;
    logic [1:0]             zone_now;
    logic signed [25:0]     blend;
    logic [21:0]            blend_pos;
    logic [30:0]            soc_prod;
    logic [12:0]            soc_raw;
    logic [SOC_W-1:0]       soc_final;
    logic                   in_xfer;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_xfer     = in_valid && in_ready;
    assign out_valid   = out_valid_reg;
    assign charge_mams = out_charge_reg;
    assign soc_tenths  = out_soc_reg;
    assign zone        = out_zone_reg;
    assign restore_ok  = out_ok_reg;

    always_comb
    begin
        cur_prod   = cur_reg * $signed({1'b0, el_reg});
        charge_sum = $signed({2'b00, charge_reg}) + 40'(cur_prod);
        if (charge_sum < 0)
            charge_clamped = '0;
        else if (charge_sum > $signed({2'b00, full_reg}))
            charge_clamped = full_reg;
        else
            charge_clamped = charge_sum[CHARGE_W-1:0];

        cap_wr  = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
        full_wr = CHARGE_W'(cap_wr) * CHARGE_W'(MS_PER_HOUR);

        if (points_reg < 4'd2)
            n_used = 4'd2;
        else if (points_reg > 4'(CURVE_DEPTH))
            n_used = 4'(CURVE_DEPTH);
        else
            n_used = points_reg;
        last_idx = PT_W'(n_used - 4'd1);

        seg_hit    = !found_reg && (v_reg <= prev_v_reg) && (v_reg >= rd_v_reg);
        seg_den    = seg_v1_reg - seg_v2_reg;
        seg_dv     = seg_v1_reg - v_reg;
        seg_ds     = $signed({1'b0, seg_s2_reg}) - $signed({1'b0, seg_s1_reg});
        seg_ds_mag = seg_ds[10] ? SOC_W'(-seg_ds) : seg_ds[SOC_W-1:0];
        seg_mag    = seg_ds_mag * seg_dv;

        charge_125 = {charge_reg, 7'b0} - {6'b0, charge_reg, 1'b0} - {7'b0, charge_reg};

        trial    = DIV_W'(dvs_reg) << dcnt_reg;
        div_ge   = (rem_reg >= trial);
        q_shift  = {q_reg[Q_W-2:0], div_ge};
        q_signed = $signed({2'b00, q_shift});

        if (v_reg > full_zone_reg)
            zone_now = ZONE_FULL;
        else if (v_reg < deep_zone_reg)
            zone_now = ZONE_DEEP;
        else
            zone_now = ZONE_MID;

        // q_reg holds the coulomb SOC once the coulomb (last) division is done
        if (zone_now == ZONE_MID)
            blend = 26'sd7 * $signed({8'b0, q_reg}) + 26'sd3 * 26'(volt_reg) + 26'sd1280;
        else
            blend = 26'sd2 * $signed({8'b0, q_reg}) + 26'sd8 * 26'(volt_reg) + 26'sd1280;
        blend_pos = (blend < 0) ? 22'd0 : blend[21:0];
        // divide by 2560: shift by 9, then multiply by the reciprocal of 5
        soc_prod  = blend_pos[21:9] * RECIP_5;
        soc_raw   = soc_prod[30:18];
        soc_final = (soc_raw > 13'(SOC_MAX)) ? SOC_MAX : soc_raw[SOC_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_APPLY && act_reg == ACT_LOAD)
        begin
            curve_v[pidx_reg] <= pv_reg;
            curve_s[pidx_reg] <= (ps_reg > SOC_MAX) ? SOC_MAX : ps_reg;
        end
        if (state_reg == S_RD)
        begin
            rd_v_reg <= curve_v[idx_reg];
            rd_s_reg <= curve_s[idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            full_reg      <= FULL_RESET;
            charge_reg    <= FULL_RESET;
            full_zone_reg <= FULL_ZONE_RST;
            deep_zone_reg <= DEEP_ZONE_RST;
            points_reg    <= POINTS_RESET;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            dcnt_reg      <= '0;
            div_coul_reg  <= 1'b0;
        end
        else
        begin
            // the final step reloads the result register itself
            if (out_valid_reg && out_ready && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        act_reg   <= action_t'(action);
                        pidx_reg  <= point_index;
                        pv_reg    <= point_voltage_mv;
                        ps_reg    <= point_soc;
                        cur_reg   <= cell_current;
                        v_reg     <= voltage_mv;
                        el_reg    <= elapsed_ms;
                        rc_reg    <= restore_charge;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    ok_reg <= 1'b0;
                    case (act_reg)
                        ACT_SAMPLE:  charge_reg <= charge_clamped;
                        ACT_RESTORE:
                        begin
                            if (rc_reg <= full_reg)
                            begin
                                charge_reg <= rc_reg;
                                ok_reg     <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    prev_v_reg <= rd_v_reg;
                    prev_s_reg <= rd_s_reg;
                    if (idx_reg == '0)
                    begin
                        if (v_reg >= rd_v_reg)
                        begin
                            volt_reg  <= $signed({2'b00, CURVE_TOP});
                            state_reg <= S_COUL;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                    else
                    begin
                        if (seg_hit)
                        begin
                            found_reg  <= 1'b1;
                            seg_v1_reg <= prev_v_reg;
                            seg_s1_reg <= prev_s_reg;
                            seg_v2_reg <= rd_v_reg;
                            seg_s2_reg <= rd_s_reg;
                        end
                        if (idx_reg == last_idx)
                        begin
                            // at or below the last point the curve reads empty
                            if (v_reg <= rd_v_reg || !(found_reg || seg_hit))
                            begin
                                volt_reg  <= '0;
                                state_reg <= S_COUL;
                            end
                            else
                                state_reg <= S_MUL;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_MUL:
                begin
                    if (seg_den == '0)
                    begin
                        volt_reg  <= $signed({2'b00, seg_s1_reg, 8'b0});
                        state_reg <= S_COUL;
                    end
                    else
                    begin
                        rem_reg      <= DIV_W'({seg_mag, 8'b0});
                        dvs_reg      <= CHARGE_W'(seg_den);
                        neg_reg      <= seg_ds[10];
                        q_reg        <= '0;
                        dcnt_reg     <= DCNT_W'(Q_W - 1);
                        div_coul_reg <= 1'b0;
                        state_reg    <= S_DIV;
                    end
                end
                S_COUL:
                begin
                    rem_reg      <= {charge_125, 11'b0};
                    dvs_reg      <= full_reg;
                    q_reg        <= '0;
                    dcnt_reg     <= DCNT_W'(Q_W - 1);
                    div_coul_reg <= 1'b1;
                    state_reg    <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_ge)
                        rem_reg <= rem_reg - trial;
                    q_reg    <= q_shift;
                    dcnt_reg <= dcnt_reg - 1'b1;
                    if (dcnt_reg == '0)
                    begin
                        if (div_coul_reg)
                            state_reg <= S_FIN;
                        else
                        begin
                            volt_reg  <= $signed({2'b00, seg_s1_reg, 8'b0})
                                         + (neg_reg ? -q_signed : q_signed);
                            state_reg <= S_COUL;
                        end
                    end
                end
                S_FIN:
                begin
                    // hold until the previous result has been taken
                    if (!out_valid_reg || out_ready)
                    begin
                        out_charge_reg <= charge_reg;
                        out_soc_reg    <= soc_final;
                        out_zone_reg   <= zone_now;
                        out_ok_reg     <= ok_reg;
                        out_valid_reg  <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CAPACITY:
                    begin
                        full_reg   <= full_wr;
                        charge_reg <= full_wr;
                    end
                    CFG_FULL_ZONE: full_zone_reg <= cfg_data[MV_W-1:0];
                    CFG_DEEP_ZONE: deep_zone_reg <= cfg_data[MV_W-1:0];
                    CFG_POINTS:    points_reg    <= cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

endmodule
